@@ hdl/gfem_pkg.sv @@
package gfem_pkg;

   // Item and register widths fixed by the interface.
   localparam int VAL_W      = 8;
   localparam int CNT_W      = 21;
   localparam int IDX_W      = 20;
   localparam int CFG_W      = 11;
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 3;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // Occupancy codes.
   localparam logic [VAL_W-1:0] VAL_UNKNOWN = 8'hFF;
   localparam logic [VAL_W-1:0] VAL_FREE    = 8'h00;
   localparam logic [VAL_W-1:0] VAL_MARK    = 8'd10;

   // Register map, selected by address bit 2.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef logic [VAL_W-1:0] val_type;

   // Three consecutive cells; element 0 is the youngest.
   typedef val_type [2:0] trio_type;

   // 3x3 tap window: near holds ages 0..2, mid ages W..W+2, far ages 2W..2W+2.
   typedef struct packed {
      trio_type far;
      trio_type mid;
      trio_type near;
   } window_type;

endpackage

@@ hdl/grid_frontier_edge_marker.sv @@
// Frontier edge marker for an occupancy grid streamed in raster order.
//
// Requests arrive on the req_ stream, one grid cell each: tdata carries the
// cell value, tuser[0] marks the first cell of a new map and tuser[1] marks a
// flush request sent after the last cell. Results leave on the rsp_ stream with
// the cell index, its value (10 when the cell is a frontier) and the frontier
// flag. The map size is set through the csr_ port while the block is idle.
//
// The block takes one request per clock cycle while rsp_ is not stalled. The
// result for cell k is produced by the request that carries cell k+W+1; it
// passes the window, margin and output registers to rsp_. The first W+1 requests
// of a map give no result, so W+1 flush requests are needed to drain a map.
// The line memory holds 2*MAX_WIDTH+1 entries of three cells and takes one
// write and two reads per cycle, which is what sets the one-cycle rate.
//
// Reset empties the pipeline, clears the arrival count and returns both size
// registers to 1024. The line memory is not cleared: only cells of the current
// map are ever used. When the receiver stalls, the output register holds the
// result and the pipeline fills; requests are refused only once it is full.
module grid_frontier_edge_marker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gfem_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] cell_value
   input  logic [gfem_pkg::REQ_USER_W-1:0]   req_tuser,  // [0] map_start, [1] is_padding
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gfem_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [19:0] cell_index,
                                                         // [27:20] marked_value, [31:28] zero
   output logic                              rsp_tuser,  // [0] is_frontier
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gfem_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [gfem_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [gfem_pkg::DATA_W-1:0]       csr_prdata,
   output logic                              csr_pready
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int TW = WW + HW;
   localparam int PAD_W = gfem_pkg::RSP_DATA_W - gfem_pkg::IDX_W - gfem_pkg::VAL_W;

   logic [WW-1:0]                 grid_w;
   logic [TW-1:0]                 grid_total;
   logic                          accept, s2_free;
   logic                          s1_vld_ff, s1_vld_in;
   logic [gfem_pkg::CNT_W-1:0]    count_ff, count_in, n_cur, n_ff, n_in;
   gfem_pkg::val_type             cell_val;
   gfem_pkg::window_type          win;
   logic [gfem_pkg::IDX_W-1:0]    out_index;
   gfem_pkg::val_type             out_value;
   logic                          out_frontier;

   gfem_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .WW         (WW),
      .HW         (HW)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .grid_w     (grid_w),
      .grid_total (grid_total)
   );

   // Stage 1 is free when empty or when its content moves on this cycle.
   assign req_tready = !s1_vld_ff || s2_free;
   assign accept     = req_tvalid && req_tready;

   // A map start restarts the count; flush requests enter the line as free
   // cells so that they never look unknown.
   assign n_cur    = req_tuser[0] ? '0 : count_ff;
   assign cell_val = req_tuser[1] ? gfem_pkg::VAL_FREE : req_tdata[gfem_pkg::VAL_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = (n_cur < gfem_pkg::COUNT_MAX) ? n_cur + gfem_pkg::CNT_W'(1)
                                                  : gfem_pkg::COUNT_MAX;
      end
   end

   assign n_in      = accept ? n_cur : n_ff;
   assign s1_vld_in = accept ? 1'b1 : (s2_free ? 1'b0 : s1_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
   end

   // Line memory and tap registers; their outputs form the stage 1 window.
   gfem_window #(
      .MAX_WIDTH (MAX_WIDTH),
      .WW        (WW)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .cell_in (cell_val),
      .grid_w  (grid_w),
      .win     (win)
   );

   // Range check, frontier decision and the output register.
   gfem_mark #(
      .WW (WW),
      .TW (TW)
   ) u_mark (
      .clock        (clock),
      .reset        (reset),
      .s1_vld       (s1_vld_ff),
      .s1_count     (n_ff),
      .win          (win),
      .grid_w       (grid_w),
      .grid_total   (grid_total),
      .s2_free      (s2_free),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_index    (out_index),
      .rsp_value    (out_value),
      .rsp_frontier (out_frontier)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, out_value, out_index};
   assign rsp_tuser = out_frontier;

endmodule

@@ hdl/gfem_csr.sv @@
module gfem_csr #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int WW         = 11,
   parameter int HW         = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [gfem_pkg::ADDR_W-1:0]  paddr,
   input  logic [gfem_pkg::DATA_W-1:0]  pwdata,
   output logic [gfem_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output logic [WW-1:0]                grid_w,
   output logic [WW+HW-1:0]             grid_total
);

   localparam int TW    = WW + HW;
   localparam int RST_W = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
   localparam int RST_H = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

   logic [gfem_pkg::CFG_W-1:0] raw_w_ff, raw_w_in, raw_h_ff, raw_h_in;
   logic [WW-1:0]              w_ff, w_in, w_new;
   logic [HW-1:0]              h_ff, h_in, h_new;
   logic [TW-1:0]              total_ff, total_in;
   logic                       wr;

   function automatic logic [WW-1:0] clamp_w(input logic [gfem_pkg::CFG_W-1:0] raw);
      logic [WW-1:0] res;
      if (raw < gfem_pkg::CFG_W'(3)) begin
         res = WW'(3);
      end else if (32'(raw) > 32'(MAX_WIDTH)) begin
         res = WW'(MAX_WIDTH);
      end else begin
         res = WW'(raw);
      end
      return res;
   endfunction

   function automatic logic [HW-1:0] clamp_h(input logic [gfem_pkg::CFG_W-1:0] raw);
      logic [HW-1:0] res;
      if (raw < gfem_pkg::CFG_W'(3)) begin
         res = HW'(3);
      end else if (32'(raw) > 32'(MAX_HEIGHT)) begin
         res = HW'(MAX_HEIGHT);
      end else begin
         res = HW'(raw);
      end
      return res;
   endfunction

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign w_new  = clamp_w(pwdata[gfem_pkg::CFG_W-1:0]);
   assign h_new  = clamp_h(pwdata[gfem_pkg::CFG_W-1:0]);

   // The area product is refreshed together with the size it depends on.
   always_comb begin
      raw_w_in = raw_w_ff;
      raw_h_in = raw_h_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      total_in = total_ff;
      if (wr) begin
         case (paddr[2])
            gfem_pkg::REG_WIDTH: begin
               raw_w_in = pwdata[gfem_pkg::CFG_W-1:0];
               w_in     = w_new;
               total_in = TW'(w_new) * TW'(h_ff);
            end
            gfem_pkg::REG_HEIGHT: begin
               raw_h_in = pwdata[gfem_pkg::CFG_W-1:0];
               h_in     = h_new;
               total_in = TW'(w_ff) * TW'(h_new);
            end
            default: begin
               total_in = total_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_w_ff <= gfem_pkg::CFG_W'(1024);
         raw_h_ff <= gfem_pkg::CFG_W'(1024);
         w_ff     <= WW'(RST_W);
         h_ff     <= HW'(RST_H);
         total_ff <= TW'(RST_W * RST_H);
      end else begin
         raw_w_ff <= raw_w_in;
         raw_h_ff <= raw_h_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         total_ff <= total_in;
      end
   end

   always_comb begin
      case (paddr[2])
         gfem_pkg::REG_WIDTH:  prdata = gfem_pkg::DATA_W'(raw_w_ff);
         gfem_pkg::REG_HEIGHT: prdata = gfem_pkg::DATA_W'(raw_h_ff);
         default:              prdata = '0;
      endcase
   end

   assign grid_w     = w_ff;
   assign grid_total = total_ff;

endmodule

@@ hdl/gfem_window.sv @@
module gfem_window #(
   parameter int MAX_WIDTH = 1024,
   parameter int WW        = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  gfem_pkg::val_type     cell_in,
   input  logic [WW-1:0]         grid_w,
   output gfem_pkg::window_type  win
);

   // Each entry holds a cell together with its two predecessors, so a single
   // read at age W (or 2W) yields three adjacent taps of that row.
   localparam int DEPTH = 2 * MAX_WIDTH + 1;
   localparam int AW    = $clog2(DEPTH);

   gfem_pkg::trio_type line_mem [DEPTH];

   gfem_pkg::trio_type near_in, near_ff, mid_ff, far_ff;
   gfem_pkg::val_type  hist1_ff, hist1_in, hist2_ff, hist2_in;
   logic [AW-1:0]      wp_ff, wp_in, wa, ra_mid, ra_far;
   logic [AW:0]        base, age_w, age_2w, mid_full, far_full;

   assign near_in[0] = cell_in;
   assign near_in[1] = hist1_ff;
   assign near_in[2] = hist2_ff;

   assign hist1_in = load ? cell_in : hist1_ff;
   assign hist2_in = load ? hist1_ff : hist2_ff;

   assign wa    = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
   assign wp_in = load ? wa : wp_ff;

   assign base   = {1'b0, wa};
   assign age_w  = (AW+1)'(grid_w);
   assign age_2w = age_w << 1;

   assign mid_full = (base >= age_w) ? base - age_w : base + (AW+1)'(DEPTH) - age_w;
   assign far_full = (base >= age_2w) ? base - age_2w : base + (AW+1)'(DEPTH) - age_2w;
   assign ra_mid   = mid_full[AW-1:0];
   assign ra_far   = far_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      hist1_ff <= hist1_in;
      hist2_ff <= hist2_in;
   end

   // Reads only ever reach entries at least three writes old, so they never
   // collide with the entry being written in the same cycle.
   always_ff @(posedge clock) begin
      if (load) begin
         line_mem[wa] <= near_in;
         mid_ff       <= line_mem[ra_mid];
         far_ff       <= line_mem[ra_far];
         near_ff      <= near_in;
      end
   end

   always_comb begin
      win.near = near_ff;
      win.mid  = mid_ff;
      win.far  = far_ff;
   end

endmodule

@@ hdl/gfem_mark.sv @@
module gfem_mark #(
   parameter int WW = 11,
   parameter int TW = 22
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           s1_vld,
   input  logic [gfem_pkg::CNT_W-1:0]     s1_count,
   input  gfem_pkg::window_type           win,
   input  logic [WW-1:0]                  grid_w,
   input  logic [TW-1:0]                  grid_total,
   output logic                           s2_free,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gfem_pkg::IDX_W-1:0]     rsp_index,
   output gfem_pkg::val_type              rsp_value,
   output logic                           rsp_frontier
);

   localparam int DW = ((gfem_pkg::CNT_W > TW) ? gfem_pkg::CNT_W : TW) + 2;

   logic signed [DW-1:0] n_s, w_s, t_s, c_s, one_s;
   logic signed [DW-1:0] p_in, p_ff, q_in, q_ff;
   logic signed [DW-1:0] reach [4];
   logic                 has_res, s2_load, s3_free, s3_load, hit, frontier;
   logic                 s2_vld_ff, s2_vld_in, rsp_vld_ff, rsp_vld_in;
   logic [3:0]           plus_ok, minus_ok;
   logic [7:0]           unk_in, unk_ff;
   logic [gfem_pkg::IDX_W-1:0] idx_in, idx_ff, out_idx_ff;
   gfem_pkg::val_type    center_in, center_ff, out_val_ff, out_val_in;
   logic                 out_fr_ff;

   // Stage 2 entry: reported index c = n-W-1, and the neighbour range
   // W+1 .. total-W-2 rewritten as margins p = c-(W+1) and q = total-W-2-c.
   assign n_s   = signed'(DW'(s1_count));
   assign w_s   = signed'(DW'(grid_w));
   assign t_s   = signed'(DW'(grid_total));
   assign one_s = signed'(DW'(1));
   assign c_s   = n_s - w_s - one_s;
   assign p_in  = c_s - w_s - one_s;
   assign q_in  = t_s - n_s - one_s;
   assign has_res = (c_s >= signed'(DW'(0))) && (c_s < t_s);
   assign idx_in  = c_s[gfem_pkg::IDX_W-1:0];

   // Neighbours after the cell, by offset 1, W-1, W, W+1, then those before.
   always_comb begin
      center_in = win.mid[1];
      unk_in[0] = (win.mid[0]  == gfem_pkg::VAL_UNKNOWN);
      unk_in[1] = (win.near[2] == gfem_pkg::VAL_UNKNOWN);
      unk_in[2] = (win.near[1] == gfem_pkg::VAL_UNKNOWN);
      unk_in[3] = (win.near[0] == gfem_pkg::VAL_UNKNOWN);
      unk_in[4] = (win.mid[2]  == gfem_pkg::VAL_UNKNOWN);
      unk_in[5] = (win.far[0]  == gfem_pkg::VAL_UNKNOWN);
      unk_in[6] = (win.far[1]  == gfem_pkg::VAL_UNKNOWN);
      unk_in[7] = (win.far[2]  == gfem_pkg::VAL_UNKNOWN);
   end

   assign s3_free   = !rsp_vld_ff || rsp_ready;
   assign s2_free   = !s2_vld_ff || s3_free;
   assign s2_load   = s2_free && s1_vld;
   assign s2_vld_in = s2_free ? (s1_vld && has_res) : s2_vld_ff;
   assign s3_load   = s3_free && s2_vld_ff;
   assign rsp_vld_in = s3_free ? s2_vld_ff : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         p_ff      <= p_in;
         q_ff      <= q_in;
         idx_ff    <= idx_in;
         center_ff <= center_in;
         unk_ff    <= unk_in;
      end
   end

   // A neighbour at c+d is in range when p >= -d and q >= d; one at c-d when
   // p >= d and q >= -d (which also keeps c-d non-negative).
   always_comb begin
      reach[0] = one_s;
      reach[1] = w_s - one_s;
      reach[2] = w_s;
      reach[3] = w_s + one_s;
      for (int k = 0; k < 4; k++) begin
         plus_ok[k]  = (p_ff >= -reach[k]) && (q_ff >= reach[k]);
         minus_ok[k] = (p_ff >= reach[k]) && (q_ff >= -reach[k]);
      end
   end

   assign hit        = |((unk_ff[3:0] & plus_ok) | (unk_ff[7:4] & minus_ok));
   assign frontier   = (center_ff == gfem_pkg::VAL_FREE) && hit;
   assign out_val_in = frontier ? gfem_pkg::VAL_MARK : center_ff;

   always_ff @(posedge clock) begin
      if (s3_load) begin
         out_idx_ff <= idx_ff;
         out_val_ff <= out_val_in;
         out_fr_ff  <= frontier;
      end
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_index    = out_idx_ff;
   assign rsp_value    = out_val_ff;
   assign rsp_frontier = out_fr_ff;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   // Testbench for the occupancy-grid frontier edge marker.
   //
   // Each request carries one grid cell in raster order. The block reports cell
   // k once cell k+W+1 has arrived, so that its eight linear neighbours are all
   // at hand. A free cell next to an unknown cell inside the scanned range comes
   // back marked as a frontier; every other cell passes through unchanged.
   //
   // The bench keeps its own model of the block: a history of the last 2*MAX_SIDE+3
   // cell values, the count of requests seen in the current map and its own
   // copy of both size registers. Every accepted request is stepped through that
   // model; a result it produces joins the queue of awaited marks unless the
   // request is unchecked or carries a typed mark. Results leaving the block are
   // matched in order against that queue, field by field.
   // Stimulus falls into three parts. A short scripted sequence comes first: the
   // warm-up straight after reset, a 3 x 3 map with cells outside the scanned
   // range, an early flush request, a flush overrun, a size change in the middle
   // of a map and a map abandoned before its flush. Where a row's outcome is
   // obvious it is typed into the script; the rest go through the model. Then
   // come short unfinished maps at the largest sizes, and then random maps in
   // four phases of sender and receiver idling. Sizes change only while the
   // block is drained.

   localparam int MAX_SIDE       = 1024;
   localparam int HIST_DEPTH     = 2 * MAX_SIDE + 3;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int TRUNC_MAX      = 64;
   localparam int KEEP           = -1;
   localparam int VW             = gfem_pkg::VAL_W;
   localparam int CW             = gfem_pkg::CNT_W;

   localparam logic [VW-1:0] V_UNK  = gfem_pkg::VAL_UNKNOWN;
   localparam logic [VW-1:0] V_FREE = gfem_pkg::VAL_FREE;

   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_TYPED} check_kind_type;
   typedef enum int {MAP_CLEAN, MAP_TRUNCATED, MAP_PADDED, MAP_HEADLESS} map_style_type;

   typedef struct packed {
      logic [gfem_pkg::IDX_W-1:0] idx;
      logic [VW-1:0]              mval;
      logic                       front;
   } mark_type;

   typedef struct {
      logic [VW-1:0]    value;
      bit               start;
      bit               pad;
      check_kind_type   kind;
      mark_type         typed;
   } cell_item_type;

   typedef struct {
      int               new_w;
      int               new_h;
      logic [VW-1:0]    value;
      bit               start;
      bit               pad;
      check_kind_type   kind;
      mark_type         typed;
   } script_row_type;

   // The scripted opening. A size pair other than KEEP is written, with the
   // block drained, before the row's request is sent.
   script_row_type script_rows [0:24] = '{
      // Default 1024 x 1024 map straight after reset: still warming up.
      '{KEEP, KEEP, V_UNK,  1'b1, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, 8'd100, 1'b0, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, V_FREE, 1'b0, 1'b0, CHECK_NONE,  '0},
      // Sizes below three clamp to 3 x 3; only cell 4 is in the scanned range.
      '{2,    0,    V_FREE, 1'b1, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, V_UNK,  1'b0, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, V_FREE, 1'b0, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, V_FREE, 1'b0, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, V_UNK,  1'b0, 1'b0, CHECK_MODEL, '0},
      '{KEEP, KEEP, V_FREE, 1'b0, 1'b0, CHECK_TYPED, '{20'd1, V_UNK, 1'b0}},
      '{KEEP, KEEP, 8'd100, 1'b0, 1'b0, CHECK_MODEL, '0},
      '{KEEP, KEEP, V_FREE, 1'b0, 1'b0, CHECK_MODEL, '0},
      // A flush request standing in for cell 8: its value field is ignored.
      '{KEEP, KEEP, V_UNK,  1'b0, 1'b1, CHECK_TYPED, '{20'd4, V_UNK, 1'b0}},
      '{KEEP, KEEP, V_UNK,  1'b0, 1'b1, CHECK_MODEL, '0},
      '{KEEP, KEEP, V_UNK,  1'b0, 1'b1, CHECK_TYPED, '{20'd6, 8'd100, 1'b0}},
      '{KEEP, KEEP, V_UNK,  1'b0, 1'b1, CHECK_MODEL, '0},
      '{KEEP, KEEP, V_UNK,  1'b0, 1'b1, CHECK_MODEL, '0},
      // One flush request too many: the map is already complete.
      '{KEEP, KEEP, V_UNK,  1'b0, 1'b1, CHECK_NONE,  '0},
      // Width four, narrowed to three in the middle of the map.
      '{4,    3,    V_FREE, 1'b1, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, V_UNK,  1'b0, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, V_FREE, 1'b0, 1'b0, CHECK_NONE,  '0},
      '{3,    4,    V_FREE, 1'b0, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, V_FREE, 1'b0, 1'b0, CHECK_MODEL, '0},
      // A new map before the old one is flushed: its pending cells are lost.
      '{KEEP, KEEP, V_UNK,  1'b1, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, V_FREE, 1'b0, 1'b0, CHECK_NONE,  '0},
      '{KEEP, KEEP, 8'd100, 1'b0, 1'b0, CHECK_NONE,  '0}
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [gfem_pkg::REQ_DATA_W-1:0]    req_tdata = '0;
   logic [gfem_pkg::REQ_USER_W-1:0]    req_tuser = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [gfem_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                               rsp_tuser;
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [gfem_pkg::ADDR_W-1:0]        csr_paddr = '0;
   logic [gfem_pkg::DATA_W-1:0]        csr_pwdata = '0;
   logic [gfem_pkg::DATA_W-1:0]        csr_prdata;
   logic                               csr_pready;

   // The bench's own copy of the block's state.
   logic [VW-1:0]                 cell_hist [0:HIST_DEPTH-1];
   int unsigned                   hist_pos = 0;
   logic [CW-1:0]                 map_count = '0;
   logic [gfem_pkg::CFG_W-1:0]    width_reg = 11'd1024;
   logic [gfem_pkg::CFG_W-1:0]    height_reg = 11'd1024;

   cell_item_type send_q [$];
   mark_type      pending_marks [$];
   cell_item_type offer;
   bit            req_busy = 1'b0;
   mark_type      step_mark;
   mark_type      want_mark;
   mark_type      got_mark;
   bit            step_has;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_trigger = 1'b0;
   bit          hold_seen = 1'b0;
   int          hold_left = 0;
   int          fail_count = 0;
   int unsigned cycle_count = 0;

   grid_frontier_edge_marker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   initial begin
      foreach (cell_hist[i]) cell_hist[i] = V_FREE;
   end

   function automatic int unsigned clamp_side(input int unsigned v);
      if (v < 3) return 3;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
   endfunction

   // Value of the cell that arrived 'age' requests ago; age 0 is the newest.
   function automatic logic [VW-1:0] aged_cell(input int unsigned age);
      return cell_hist[(hist_pos + HIST_DEPTH - age % HIST_DEPTH) % HIST_DEPTH];
   endfunction

   function automatic bit unknown_cell(input int unsigned j, input int unsigned age,
                                       input int unsigned w, input int unsigned total);
      if (j < w + 1 || j > total - w - 2) return 1'b0;
      return aged_cell(age) == gfem_pkg::VAL_UNKNOWN;
   endfunction

   // Steps the model by one request. Returns 1 when the request releases the
   // mark of an earlier cell, which is then written to 'mark'.
   function automatic bit frontier_step(input cell_item_type it, output mark_type mark);
      int unsigned      w, h, total, n, c, d;
      logic [VW-1:0]    centre;
      bit               hit;
      w = clamp_side(32'(width_reg));
      h = clamp_side(32'(height_reg));
      total = w * h;
      n = it.start ? 0 : 32'(map_count);
      hist_pos = (hist_pos + 1) % HIST_DEPTH;
      cell_hist[hist_pos] = it.pad ? gfem_pkg::VAL_FREE : it.value;
      map_count = (n < gfem_pkg::COUNT_MAX) ? CW'(n + 1) : gfem_pkg::COUNT_MAX;
      mark = '0;
      if (n < w + 1) return 1'b0;
      c = n - w - 1;
      if (c >= total) return 1'b0;
      centre = aged_cell(w + 1);
      hit = 1'b0;
      if (centre == gfem_pkg::VAL_FREE) begin
         // Neighbour distances 1, W-1, W and W+1 on both sides.
         for (int k = 0; k < 4; k++) begin
            d = (k == 0) ? 1 : w - 2 + k;
            if (unknown_cell(c + d, w + 1 - d, w, total)) hit = 1'b1;
            if (c >= d && unknown_cell(c - d, w + 1 + d, w, total)) hit = 1'b1;
         end
      end
      mark.idx = c[gfem_pkg::IDX_W-1:0];
      mark.mval = hit ? gfem_pkg::VAL_MARK : centre;
      mark.front = hit;
      return 1'b1;
   endfunction

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Request and result streams. An accepted request is stepped through the
   // model before the result check, so its mark is already queued should the
   // block ever answer at once.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_busy = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            step_has = frontier_step(offer, step_mark);
            if (offer.kind == CHECK_TYPED) pending_marks = {pending_marks, offer.typed};
            else if (offer.kind == CHECK_MODEL && step_has)
               pending_marks = {pending_marks, step_mark};
            req_busy = 1'b0;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_mark.idx = rsp_tdata[gfem_pkg::IDX_W-1:0];
            got_mark.mval = rsp_tdata[gfem_pkg::IDX_W+VW-1:gfem_pkg::IDX_W];
            got_mark.front = rsp_tuser;
            if (pending_marks.size() == 0) begin
               $display("%0t: unexpected result, expected none, got index %0d value %0d",
                        $time, got_mark.idx, $signed(got_mark.mval));
               fail_count++;
            end else begin
               want_mark = pending_marks.pop_front();
               report_field("cell_index", want_mark.idx, got_mark.idx);
               report_field("marked_value", $signed(want_mark.mval), $signed(got_mark.mval));
               report_field("is_frontier", want_mark.front, got_mark.front);
            end
         end
         // A request on offer stays until it is taken; a new one may follow
         // an idle cycle at random.
         if (!req_busy && send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offer = send_q.pop_front();
            req_busy = 1'b1;
            req_tdata <= offer.value;
            req_tuser <= {offer.pad, offer.start};
         end
         req_tvalid <= req_busy;
      end
   end

   // Receiver: random stalls, or a long hold-off whenever the trigger flips.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic csr_read_check(input logic reg_sel,
                                 input logic [gfem_pkg::DATA_W-1:0] want);
      logic [gfem_pkg::DATA_W-1:0] got;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {reg_sel, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         $display("%0t: register %0d read back, expected %0d, got %0d",
                  $time, reg_sel, want, got);
         fail_count++;
      end
   endtask

   task automatic csr_write(input logic reg_sel, input logic [gfem_pkg::DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_sel == gfem_pkg::REG_WIDTH) width_reg = data[gfem_pkg::CFG_W-1:0];
      else height_reg = data[gfem_pkg::CFG_W-1:0];
      csr_read_check(reg_sel, {{(gfem_pkg::DATA_W-gfem_pkg::CFG_W){1'b0}},
                               data[gfem_pkg::CFG_W-1:0]});
   endtask

   // Waits until nothing is queued, on offer or awaited, then lets the
   // pipeline settle, since warm-up cells may still be inside it.
   task automatic wait_drained();
      while (send_q.size() != 0 || req_busy || pending_marks.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // New map size; the unused upper bits of the write data are random.
   task automatic set_size(input int unsigned w_raw, input int unsigned h_raw);
      wait_drained();
      csr_write(gfem_pkg::REG_WIDTH, ($urandom() & 32'hFFFF_F800) | w_raw);
      csr_write(gfem_pkg::REG_HEIGHT, ($urandom() & 32'hFFFF_F800) | h_raw);
   endtask

   function automatic int unsigned pick_side();
      int r;
      r = $urandom_range(99);
      if (r < 85) return $urandom_range(8, 3);
      if (r < 93) return $urandom_range(2, 0);
      return $urandom_range(20, 9);
   endfunction

   function automatic logic [VW-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 35) return gfem_pkg::VAL_UNKNOWN;
      if (r < 70) return gfem_pkg::VAL_FREE;
      return VW'($urandom_range(100, 1));
   endfunction

   // Queues one map at the current size. A truncated map stops short, after
   // at most TRUNC_MAX cells, and is never flushed; a padded one has flush
   // requests among its cells and a few spare at the end; a headless one lacks
   // its map start and so carries on counting from whatever came before.
   task automatic queue_map(input map_style_type style, inout int queued);
      int unsigned    w, h, cells, cut, tail, limit;
      cell_item_type  it;
      w = clamp_side(32'(width_reg));
      h = clamp_side(32'(height_reg));
      cells = w * h;
      limit = (cells - 1 < 4 * w) ? cells - 1 : 4 * w;
      if (limit > TRUNC_MAX) limit = TRUNC_MAX;
      cut = (style == MAP_TRUNCATED) ? $urandom_range(limit, 1) : cells;
      case (style)
         MAP_TRUNCATED: tail = 0;
         MAP_PADDED:    tail = w + 1 + $urandom_range(3, 1);
         default:       tail = w + 1;
      endcase
      it.kind = CHECK_MODEL;
      it.typed = '0;
      @(negedge clock);
      for (int k = 0; k < cut + tail; k++) begin
         it.start = (k == 0) && (style != MAP_HEADLESS);
         it.pad = (k >= cut) || (style == MAP_PADDED && $urandom_range(7) == 0);
         it.value = it.pad ? VW'($urandom_range(255)) : pick_value();
         send_q = {send_q, it};
      end
      queued += cut + tail;
   endtask

   initial begin
      int             queued;
      int             r;
      map_style_type  style;
      cell_item_type  row_item;
      int             idle_send [0:3];
      int             idle_recv [0:3];
      idle_send = '{0, 51, 0, 13};
      idle_recv = '{0, 0, 51, 13};
      queued = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      csr_read_check(gfem_pkg::REG_WIDTH, 32'd1024);
      csr_read_check(gfem_pkg::REG_HEIGHT, 32'd1024);

      foreach (script_rows[i]) begin
         if (script_rows[i].new_w != KEEP) set_size(script_rows[i].new_w, script_rows[i].new_h);
         @(negedge clock);
         row_item.value = script_rows[i].value;
         row_item.start = script_rows[i].start;
         row_item.pad = script_rows[i].pad;
         row_item.kind = script_rows[i].kind;
         row_item.typed = script_rows[i].typed;
         send_q = {send_q, row_item};
      end

      // Short unfinished maps at the largest sizes: the widest at its lowest
      // height, the largest area, then the tallest at its narrowest width.
      set_size(2047, 3);
      queue_map(MAP_TRUNCATED, queued);
      set_size(1024, 2047);
      queue_map(MAP_TRUNCATED, queued);
      set_size(3, 2047);
      queue_map(MAP_TRUNCATED, queued);

      for (int ph = 0; ph < 4; ph++) begin
         @(negedge clock);
         send_idle_pct = idle_send[ph];
         recv_stall_pct = idle_recv[ph];
         queued = 0;
         if (ph == 0) begin
            // The receiver holds off while a whole map is on offer, so the
            // block fills and has to refuse requests.
            set_size(16, 6);
            hold_trigger = ~hold_trigger;
            queue_map(MAP_CLEAN, queued);
         end
         while (queued < RANDOM_ITEMS / 4) begin
            if ($urandom_range(1) == 0) set_size(pick_side(), pick_side());
            r = $urandom_range(99);
            if (r < 70) style = MAP_CLEAN;
            else if (r < 80) style = MAP_TRUNCATED;
            else if (r < 92) style = MAP_PADDED;
            else style = MAP_HEADLESS;
            queue_map(style, queued);
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
